### rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants for the script lexer stream
// Token kinds, scan modes, payload structs and the keyword match function.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int SOURCE_BYTES_DEF  = 65536;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACE   = 6'd2;
  localparam logic [5:0] K_RBRACE   = 6'd3;
  localparam logic [5:0] K_LBRACK   = 6'd4;
  localparam logic [5:0] K_RBRACK   = 6'd5;
  localparam logic [5:0] K_COMMA    = 6'd6;
  localparam logic [5:0] K_DOT      = 6'd7;
  localparam logic [5:0] K_SEMI     = 6'd8;
  localparam logic [5:0] K_COLON    = 6'd9;
  localparam logic [5:0] K_BANG     = 6'd10;
  localparam logic [5:0] K_EQ       = 6'd12;
  localparam logic [5:0] K_LT       = 6'd14;
  localparam logic [5:0] K_GT       = 6'd16;
  localparam logic [5:0] K_PLUS     = 6'd18;
  localparam logic [5:0] K_STAR     = 6'd20;
  localparam logic [5:0] K_MINUS    = 6'd22;
  localparam logic [5:0] K_MINUS_EQ = 6'd23;
  localparam logic [5:0] K_ARROW    = 6'd24;
  localparam logic [5:0] K_SLASH    = 6'd25;
  localparam logic [5:0] K_SLASH_EQ = 6'd26;
  localparam logic [5:0] K_IDENT    = 6'd27;
  localparam logic [5:0] K_STRING   = 6'd28;
  localparam logic [5:0] K_INT      = 6'd29;
  localparam logic [5:0] K_FLOAT    = 6'd30;
  localparam logic [5:0] K_KW_BASE  = 6'd31;
  localparam logic [5:0] K_EOF      = 6'd50;
  localparam logic [5:0] K_ERR_CHAR = 6'd51;
  localparam logic [5:0] K_ERR_STR  = 6'd52;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
  localparam logic [30:0] ACC_LIMIT = 31'd214748364;

  localparam logic [0:0] CMD_BYTE = 1'b0;
  localparam logic [0:0] CMD_END  = 1'b1;

  typedef enum logic [14:0] {
    M_IDLE    = 15'h0001,
    M_BANG    = 15'h0002,
    M_EQ      = 15'h0004,
    M_LT      = 15'h0008,
    M_GT      = 15'h0010,
    M_PLUS    = 15'h0020,
    M_STAR    = 15'h0040,
    M_MINUS   = 15'h0080,
    M_SLASH   = 15'h0100,
    M_COMMENT = 15'h0200,
    M_STRING  = 15'h0400,
    M_IDENT   = 15'h0800,
    M_INT     = 15'h1000,
    M_INT_DOT = 15'h2000,
    M_FRAC    = 15'h4000
  } scan_mode_t;

  typedef struct packed {
    logic [0:0] cmd;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] tok_start;
    logic [15:0] tok_end;
    logic [30:0] int_value;
    logic [15:0] error_count;
    logic [0:0]  last;
  } out_item_t;

  // Up to three results per input, handed from the front to the queue
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } burst_t;

  function automatic out_item_t mk(input logic [5:0] k, input logic [15:0] s,
                                   input logic [15:0] e, input logic [30:0] v,
                                   input logic [15:0] err);
    out_item_t r;
    r.kind = k; r.tok_start = s; r.tok_end = e; r.int_value = v;
    r.error_count = err; r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [5:0] op_single(input scan_mode_t m);
    logic [5:0] k;
    case (m)
      M_BANG:  k = K_BANG;
      M_EQ:    k = K_EQ;
      M_LT:    k = K_LT;
      M_GT:    k = K_GT;
      M_PLUS:  k = K_PLUS;
      M_STAR:  k = K_STAR;
      M_MINUS: k = K_MINUS;
      M_SLASH: k = K_SLASH;
      default: k = K_LPAREN;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // Keyword lookup over the first six buffered characters
  function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [3:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      4'd2: begin
        if (w[15:0] == "fi") k = 6'd37;
        else if (w[15:0] == "ro") k = 6'd39;
      end
      4'd3: begin
        case (w[23:0])
          "dna": k = 6'd31;
          "rof": k = 6'd35;
          "nuf": k = 6'd36;
          "lin": k = 6'd38;
          "rav": k = 6'd45;
          "wen": k = 6'd47;
          default: k = K_IDENT;
        endcase
      end
      4'd4: begin
        case (w[31:0])
          "esle": k = 6'd33;
          "siht": k = 6'd43;
          "eurt": k = 6'd44;
          default: k = K_IDENT;
        endcase
      end
      4'd5: begin
        case (w[39:0])
          "ssalc": k = 6'd32;
          "eslaf": k = 6'd34;
          "tnirp": k = 6'd40;
          "repus": k = 6'd42;
          "elihw": k = 6'd46;
          "tsnoc": k = 6'd49;
          default: k = K_IDENT;
        endcase
      end
      4'd6: begin
        if (w == "nruter") k = 6'd41;
        else if (w == "citats") k = 6'd48;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/sls_front.sv
// ----------------------------------------------------------------------------
// sls_front: scanner state machine
// Classifies each byte and produces a burst of zero to three tokens.
// ----------------------------------------------------------------------------
module sls_front #(
  parameter int SOURCE_BYTES  = sls_pkg::SOURCE_BYTES_DEF,
  parameter int KEYWORD_CHARS = sls_pkg::KEYWORD_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  sls_pkg::in_item_t item,
  output sls_pkg::burst_t   burst
);
  import sls_pkg::*;

  localparam int PW = $clog2(SOURCE_BYTES) + 1;
  localparam int LW = $clog2(KEYWORD_CHARS + 2);

  scan_mode_t       mode_r, mode_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [15:0]      org_r, org_nxt;
  logic             quote_r, quote_nxt;
  logic [30:0]      acc_r, acc_nxt;
  logic [7:0]       word_r [KEYWORD_CHARS];
  logic [LW-1:0]    wlen_r, wlen_nxt;
  logic [15:0]      fault_r, fault_nxt;
  logic             wr_en;
  logic [7:0]       wr_ch;
  logic [47:0]      wpack;
  logic [3:0]       wlen4;
  logic [15:0]      p16, p1;
  logic [7:0]       c;
  logic             consumed;
  logic [1:0]       n;
  out_item_t        rs [3];
  logic [3:0]       dig;
  logic [34:0]      acc10;

  function automatic logic [15:0] fault_inc(input logic [15:0] f);
    return (f == 16'hFFFF) ? f : f + 16'd1;
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) wpack[i*8 +: 8] = word_r[i];
    wlen4 = (int'(wlen_r) > KEYWORD_CHARS) ? 4'd15 : 4'(wlen_r);
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    org_nxt   = org_r;
    quote_nxt = quote_r;
    acc_nxt   = acc_r;
    wlen_nxt  = wlen_r;
    fault_nxt = fault_r;
    wr_en     = 1'b0;
    wr_ch     = item.ch;
    c         = item.ch;
    p16       = pos_r[15:0];
    p1        = p16 + 16'd1;
    consumed  = 1'b1;
    n         = 2'd0;
    dig       = 4'(c - "0");
    acc10     = {4'd0, acc_r} * 35'd10 + 35'(dig);
    for (int i = 0; i < 3; i++) rs[i] = '0;

    if (item.cmd == CMD_END) begin
      consumed = 1'b1;
      // flush pending token
      case (mode_r)
        M_BANG, M_EQ, M_LT, M_GT, M_PLUS, M_STAR, M_MINUS, M_SLASH: begin
          rs[n] = mk(op_single(mode_r), org_r, org_r + 16'd1, '0, '0); n = n + 2'd1;
        end
        M_STRING: begin
          fault_nxt = fault_inc(fault_r);
          rs[n] = mk(K_ERR_STR, org_r, p16, '0, '0); n = n + 2'd1;
        end
        M_IDENT: begin rs[n] = mk(word_kind(wpack, wlen4), org_r, p16, '0, '0); n = n + 2'd1; end
        M_INT:   begin rs[n] = mk(K_INT, org_r, p16, acc_r, '0); n = n + 2'd1; end
        M_INT_DOT: begin
          rs[0] = mk(K_INT, org_r, p16 - 16'd1, acc_r, '0);
          rs[1] = mk(K_DOT, p16 - 16'd1, p16, '0, '0); n = 2'd2;
        end
        M_FRAC: begin rs[n] = mk(K_FLOAT, org_r, p16, '0, '0); n = n + 2'd1; end
        default: ;
      endcase
      rs[n] = mk(K_EOF, p16, p16, '0, fault_nxt); n = n + 2'd1;
      mode_nxt = M_IDLE; pos_nxt = '0; org_nxt = '0; quote_nxt = 1'b0;
      acc_nxt = '0; wlen_nxt = '0; fault_nxt = '0;
    end else if (pos_r < PW'(SOURCE_BYTES)) begin
      case (mode_r)
        M_BANG, M_EQ, M_LT, M_GT, M_PLUS, M_STAR: begin
          if (c == "=") begin
            rs[0] = mk(op_single(mode_r) + 6'd1, org_r, p1, '0, '0); n = 2'd1;
            mode_nxt = M_IDLE;
          end else consumed = 1'b0;
        end
        M_MINUS: begin
          if (c == ">" || c == "=") begin
            rs[0] = mk((c == ">") ? K_ARROW : K_MINUS_EQ, org_r, p1, '0, '0); n = 2'd1;
            mode_nxt = M_IDLE;
          end else consumed = 1'b0;
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_COMMENT;
          else if (c == "=") begin
            rs[0] = mk(K_SLASH_EQ, org_r, p1, '0, '0); n = 2'd1;
            mode_nxt = M_IDLE;
          end else consumed = 1'b0;
        end
        M_COMMENT: if (c == 8'h0A) mode_nxt = M_IDLE;
        M_STRING: begin
          if (c == (quote_r ? 8'h27 : 8'h22)) begin
            rs[0] = mk(K_STRING, org_r, p1, '0, '0); n = 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            wr_en = int'(wlen_r) < KEYWORD_CHARS;
            if (int'(wlen_r) <= KEYWORD_CHARS) wlen_nxt = wlen_r + LW'(1);
          end else consumed = 1'b0;
        end
        M_INT: begin
          if (is_digit(c)) begin
            if (acc_r > ACC_LIMIT || acc10 > 35'(INT_MAX31)) acc_nxt = INT_MAX31;
            else acc_nxt = acc10[30:0];
          end else if (c == ".") mode_nxt = M_INT_DOT;
          else consumed = 1'b0;
        end
        M_INT_DOT: if (is_digit(c)) mode_nxt = M_FRAC; else consumed = 1'b0;
        M_FRAC:    if (!is_digit(c)) consumed = 1'b0;
        default:   consumed = 1'b0;
      endcase

      if (!consumed) begin
        mode_nxt = M_IDLE;
        case (mode_r)
          M_BANG, M_EQ, M_LT, M_GT, M_PLUS, M_STAR, M_MINUS, M_SLASH: begin
            rs[n] = mk(op_single(mode_r), org_r, org_r + 16'd1, '0, '0); n = n + 2'd1;
          end
          M_IDENT: begin
            rs[n] = mk(word_kind(wpack, wlen4), org_r, p16, '0, '0); n = n + 2'd1;
          end
          M_INT: begin rs[n] = mk(K_INT, org_r, p16, acc_r, '0); n = n + 2'd1; end
          M_INT_DOT: begin
            rs[0] = mk(K_INT, org_r, p16 - 16'd1, acc_r, '0);
            rs[1] = mk(K_DOT, p16 - 16'd1, p16, '0, '0); n = 2'd2;
          end
          M_FRAC: begin rs[n] = mk(K_FLOAT, org_r, p16, '0, '0); n = n + 2'd1; end
          default: ;
        endcase
        // start a new token at this byte
        org_nxt = p16;
        case (c)
          "(": begin rs[n] = mk(K_LPAREN, p16, p1, '0, '0); n = n + 2'd1; end
          ")": begin rs[n] = mk(K_RPAREN, p16, p1, '0, '0); n = n + 2'd1; end
          "{": begin rs[n] = mk(K_LBRACE, p16, p1, '0, '0); n = n + 2'd1; end
          "}": begin rs[n] = mk(K_RBRACE, p16, p1, '0, '0); n = n + 2'd1; end
          "[": begin rs[n] = mk(K_LBRACK, p16, p1, '0, '0); n = n + 2'd1; end
          "]": begin rs[n] = mk(K_RBRACK, p16, p1, '0, '0); n = n + 2'd1; end
          ",": begin rs[n] = mk(K_COMMA, p16, p1, '0, '0); n = n + 2'd1; end
          ".": begin rs[n] = mk(K_DOT, p16, p1, '0, '0); n = n + 2'd1; end
          ";": begin rs[n] = mk(K_SEMI, p16, p1, '0, '0); n = n + 2'd1; end
          ":": begin rs[n] = mk(K_COLON, p16, p1, '0, '0); n = n + 2'd1; end
          "!": mode_nxt = M_BANG;
          "=": mode_nxt = M_EQ;
          "<": mode_nxt = M_LT;
          ">": mode_nxt = M_GT;
          "+": mode_nxt = M_PLUS;
          "*": mode_nxt = M_STAR;
          "-": mode_nxt = M_MINUS;
          "/": mode_nxt = M_SLASH;
          8'h20, 8'h0D, 8'h09, 8'h0A: ;
          8'h22: begin mode_nxt = M_STRING; quote_nxt = 1'b0; end
          8'h27: begin mode_nxt = M_STRING; quote_nxt = 1'b1; end
          default: begin
            if (is_digit(c)) begin
              mode_nxt = M_INT;
              acc_nxt = 31'(dig);
            end else if (is_alpha(c)) begin
              mode_nxt = M_IDENT;
              wr_en = 1'b1;
              wlen_nxt = LW'(1);
            end else begin
              fault_nxt = fault_inc(fault_r);
              rs[n] = mk(K_ERR_CHAR, p16, p1, '0, '0); n = n + 2'd1;
            end
          end
        endcase
      end
      pos_nxt = pos_r + PW'(1);
    end

    if (n != 2'd0) rs[n - 2'd1].last = 1'b1;
    burst.count = step ? n : 2'd0;
    burst.r0 = rs[0];
    burst.r1 = rs[1];
    burst.r2 = rs[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      org_r   <= '0;
      quote_r <= 1'b0;
      acc_r   <= '0;
      wlen_r  <= '0;
      fault_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      org_r   <= org_nxt;
      quote_r <= quote_nxt;
      acc_r   <= acc_nxt;
      wlen_r  <= wlen_nxt;
      fault_r <= fault_nxt;
    end
  end

  // Keyword buffer: write the new character at the current length, or at index 0 for a new word
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      if (mode_r == M_IDENT && consumed) word_r[wlen_r[$clog2(KEYWORD_CHARS)-1:0]] <= wr_ch;
      else word_r[0] <= wr_ch;
    end
  end

endmodule

### rtl/sls_queue.sv
// ----------------------------------------------------------------------------
// sls_queue: token queue and output register
// Takes bursts of up to three tokens and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sls_queue #(
  parameter int DEPTH = sls_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sls_pkg::burst_t    burst,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sls_pkg::out_item_t out_data
);
  import sls_pkg::*;

  localparam int AW = $clog2(DEPTH);

  out_item_t     mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic [AW-1:0] w1, w2;

  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  // need room for a full burst
  assign room      = int'(cnt_r) <= DEPTH - 3;
  assign w1        = wp_r + AW'(1);
  assign w2        = wp_r + AW'(2);
  assign cnt_nxt   = cnt_r + (AW+1)'(burst.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(burst.count);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (burst.count >= 2'd1) mem_r[wp_r] <= burst.r0;
    if (burst.count >= 2'd2) mem_r[w1]   <= burst.r1;
    if (burst.count == 2'd3) mem_r[w2]   <= burst.r2;
  end

endmodule

### rtl/script_lexer_stream.sv
// ----------------------------------------------------------------------------
// script_lexer_stream: streaming tokenizer
// Source bytes in, tokens out, one byte per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per source byte (cmd = byte) or end of source
//           (cmd = end). End flushes any pending token and emits EOF with
//           the saturating error count, then the scanner restarts at offset 0.
//   out_* : one transaction per token; last marks the final token caused by
//           one input transaction.
// Throughput: one input byte per cycle while the token queue has room for a
//   full burst of three tokens; tokens drain one per cycle while out_ready is high.
// Token path: a token is written into the queue registers when the byte that
//   ends it is accepted (often the byte following the token), behind any older tokens.
// Reset: rst_n is synchronous; the scanner returns to idle at offset 0 and
//   the queue empties. No clearing pass is needed.
// Stall: when the receiver holds out_ready low the queue fills and in_ready
//   drops; no token is lost or repeated.
// ----------------------------------------------------------------------------
module script_lexer_stream #(
  parameter int SOURCE_BYTES  = sls_pkg::SOURCE_BYTES_DEF,
  parameter int KEYWORD_CHARS = sls_pkg::KEYWORD_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sls_pkg::out_item_t out_data
);
  import sls_pkg::*;

  logic   step;
  burst_t burst;

  // advance the scanner only when the queue can absorb the worst-case burst
  assign step = in_valid && in_ready;

  sls_front #(
    .SOURCE_BYTES (SOURCE_BYTES),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (in_data),
    .burst(burst)
  );

  sls_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .burst    (burst),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### tb/script_lexer_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_lexer_stream_checker: token predictor and scoreboard
// Watches both channels, predicts the tokens of each accepted byte or end
// marker and compares every accepted token with the oldest prediction.
// ----------------------------------------------------------------------------
module script_lexer_stream_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sls_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sls_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import sls_pkg::*;

  localparam logic [31:0] SRC_LIMIT = 32'd65536;
  localparam int          WORD_MAX  = 6;

  string kw_names[19] = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                          "print", "return", "super", "this", "true", "var", "while",
                          "new", "static", "const"};

  scan_mode_t  mode;
  logic [31:0] pos, origin, acc;
  bit          single_quote;
  logic [7:0]  word_buf[WORD_MAX];
  int          word_len;
  logic [15:0] faults;

  out_item_t token_burst[$];
  out_item_t expected_tokens[$];

  assign pending = expected_tokens.size();

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] operator_kind(input scan_mode_t m);
    case (m)
      M_BANG:  return K_BANG;
      M_EQ:    return K_EQ;
      M_LT:    return K_LT;
      M_GT:    return K_GT;
      M_PLUS:  return K_PLUS;
      M_STAR:  return K_STAR;
      M_MINUS: return K_MINUS;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] word_token_kind();
    bit hit;
    for (int i = 0; i < 19; i++) begin
      if (word_len <= WORD_MAX && kw_names[i].len() == word_len) begin
        hit = 1;
        for (int j = 0; j < word_len; j++)
          if (word_buf[j] != kw_names[i][j]) hit = 0;
        if (hit) return K_KW_BASE + 6'(i);
      end
    end
    return K_IDENT;
  endfunction

  function automatic void emit(input logic [5:0] k, input logic [31:0] s,
                               input logic [31:0] e, input logic [31:0] v = 0,
                               input logic [15:0] err = 0);
    out_item_t t;
    t.kind = k; t.tok_start = s[15:0]; t.tok_end = e[15:0];
    t.int_value = v[30:0]; t.error_count = err; t.last = 1'b0;
    token_burst.push_back(t);
  endfunction

  function automatic void bump_faults();
    if (faults != 16'hFFFF) faults++;
  endfunction

  function automatic void word_push(input logic [7:0] c);
    if (word_len < WORD_MAX) word_buf[word_len] = c;
    if (word_len <= WORD_MAX) word_len++;
  endfunction

  function automatic void clear_scan();
    mode = M_IDLE; pos = 0; origin = 0; single_quote = 0; acc = 0;
    word_len = 0; faults = 0;
  endfunction

  // Close whatever token is open and return to idle
  function automatic void close_token();
    scan_mode_t m;
    m = mode;
    mode = M_IDLE;
    case (m)
      M_BANG, M_EQ, M_LT, M_GT, M_PLUS, M_STAR, M_MINUS, M_SLASH:
        emit(operator_kind(m), origin, origin + 1);
      M_STRING: begin
        bump_faults();
        emit(K_ERR_STR, origin, pos);
      end
      M_IDENT:   emit(word_token_kind(), origin, pos);
      M_INT:     emit(K_INT, origin, pos, acc);
      M_INT_DOT: begin
        emit(K_INT, origin, pos - 1, acc);
        emit(K_DOT, pos - 1, pos);
      end
      M_FRAC:    emit(K_FLOAT, origin, pos);
      default: ;
    endcase
  endfunction

  function automatic void open_token(input logic [7:0] c);
    origin = pos;
    case (c)
      "(": emit(K_LPAREN, pos, pos + 1);
      ")": emit(K_RPAREN, pos, pos + 1);
      "{": emit(K_LBRACE, pos, pos + 1);
      "}": emit(K_RBRACE, pos, pos + 1);
      "[": emit(K_LBRACK, pos, pos + 1);
      "]": emit(K_RBRACK, pos, pos + 1);
      ",": emit(K_COMMA, pos, pos + 1);
      ".": emit(K_DOT, pos, pos + 1);
      ";": emit(K_SEMI, pos, pos + 1);
      ":": emit(K_COLON, pos, pos + 1);
      "!": mode = M_BANG;
      "=": mode = M_EQ;
      "<": mode = M_LT;
      ">": mode = M_GT;
      "+": mode = M_PLUS;
      "*": mode = M_STAR;
      "-": mode = M_MINUS;
      "/": mode = M_SLASH;
      " ", 8'h0D, 8'h09, 8'h0A: ;
      8'h22: begin mode = M_STRING; single_quote = 0; end
      8'h27: begin mode = M_STRING; single_quote = 1; end
      default: begin
        if (digit(c)) begin
          mode = M_INT;
          acc = 32'(c - "0");
        end else if (letter(c)) begin
          mode = M_IDENT;
          word_len = 0;
          word_push(c);
        end else begin
          bump_faults();
          emit(K_ERR_CHAR, pos, pos + 1);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    bit taken;
    logic [31:0] d;
    taken = 1;
    case (mode)
      M_BANG, M_EQ, M_LT, M_GT, M_PLUS, M_STAR: begin
        if (c == "=") begin
          emit(operator_kind(mode) + 6'd1, origin, pos + 1);
          mode = M_IDLE;
        end else taken = 0;
      end
      M_MINUS: begin
        if (c == ">" || c == "=") begin
          emit(c == ">" ? K_ARROW : K_MINUS_EQ, origin, pos + 1);
          mode = M_IDLE;
        end else taken = 0;
      end
      M_SLASH: begin
        if (c == "/") mode = M_COMMENT;
        else if (c == "=") begin
          emit(K_SLASH_EQ, origin, pos + 1);
          mode = M_IDLE;
        end else taken = 0;
      end
      M_COMMENT: if (c == 8'h0A) mode = M_IDLE;
      M_STRING: begin
        if (c == (single_quote ? 8'h27 : 8'h22)) begin
          emit(K_STRING, origin, pos + 1);
          mode = M_IDLE;
        end
      end
      M_IDENT: if (letter(c) || digit(c)) word_push(c); else taken = 0;
      M_INT: begin
        if (digit(c)) begin
          d = 32'(c - "0");
          // saturate rather than wrap
          if (acc > (32'(INT_MAX31) - d) / 10) acc = 32'(INT_MAX31);
          else acc = acc * 10 + d;
        end else if (c == ".") mode = M_INT_DOT;
        else taken = 0;
      end
      M_INT_DOT: if (digit(c)) mode = M_FRAC; else taken = 0;
      M_FRAC:    if (!digit(c)) taken = 0;
      default:   taken = 0;
    endcase
    if (!taken) begin
      close_token();
      open_token(c);
    end
    pos++;
  endfunction

  function automatic void predict(input in_item_t it);
    token_burst.delete();
    if (it.cmd == CMD_END) begin
      close_token();
      emit(K_EOF, pos, pos, 0, faults);
      clear_scan();
    end else if (pos < SRC_LIMIT) begin
      scan_byte(it.ch);
    end
    if (token_burst.size() > 0) token_burst[token_burst.size() - 1].last = 1'b1;
    foreach (token_burst[i]) expected_tokens.push_back(token_burst[i]);
  endfunction

  function automatic void compare(input out_item_t got);
    out_item_t want;
    if (expected_tokens.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected token, expected none, actual %p", $time, got);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind != want.kind || got.tok_start != want.tok_start ||
        got.tok_end != want.tok_end || got.int_value != want.int_value ||
        got.error_count != want.error_count || got.last != want.last) begin
      fail_count++;
      $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
    end
  endfunction

  initial begin
    fail_count = 0;
    clear_scan();
  end

  // Compare first: a token never leaves in the cycle its byte is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) compare(out_data);
      if (in_valid && in_ready) predict(in_data);
    end
  end

endmodule

### tb/tb_script_lexer_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_lexer_stream: stimulus and verdict for the script lexer stream
// Feeds directed and random source texts through the tokenizer under varying
// sender and receiver idling; the checker predicts and scores every token.
// ----------------------------------------------------------------------------
module tb_script_lexer_stream;
  import sls_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int        send_idle_pct = 22;
  int        recv_idle_pct = 48;
  int        hold_requests = 0;
  int        bytes_sent = 0;
  int        sources_sent = 0;
  logic [7:0] src_text[$];

  string op_texts[] = '{"!=", "==", "<=", ">=", "+=", "*=", "-=", "->", "/=", "!", "=",
                        "<", ">", "+", "*", "-", "/", "(", ")", "{", "}", "[", "]",
                        ",", ".", ";", ":"};
  string kw_texts[] = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                        "print", "return", "super", "this", "true", "var", "while",
                        "new", "static", "const", "returns", "staticx", "whil"};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  script_lexer_stream u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  script_lexer_stream_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random back-pressure, plus a long hold whenever one is requested
  initial begin
    int served;
    int hold_left;
    served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one transaction; hold valid and payload until it is taken
  task automatic offer(input logic [0:0] cmd, input logic [7:0] ch);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.cmd <= cmd;
    in_data.ch <= ch;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cmd == CMD_BYTE) bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endtask

  // Send the queued text, then the end marker
  task automatic send_source();
    while (src_text.size() > 0) offer(CMD_BYTE, src_text.pop_front());
    offer(CMD_END, 8'($urandom_range(255)));
    sources_sent++;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(2))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      default: return "_";
    endcase
  endfunction

  // Append one mostly well-formed lexeme with random content
  task automatic add_lexeme();
    int n;
    case ($urandom_range(11))
      0, 1: add_text(kw_texts[$urandom_range(kw_texts.size() - 1)]);
      2: begin
        n = $urandom_range(1, 9);
        src_text.push_back(pick_letter());
        repeat (n - 1)
          src_text.push_back($urandom_range(1) ? pick_letter() : 8'("0" + $urandom_range(9)));
      end
      3: repeat ($urandom_range(1, 12)) src_text.push_back(8'("0" + $urandom_range(9)));
      4: begin
        repeat ($urandom_range(1, 3)) src_text.push_back(8'("0" + $urandom_range(9)));
        src_text.push_back(".");
        if ($urandom_range(1)) src_text.push_back(8'("0" + $urandom_range(9)));
      end
      5, 6: add_text(op_texts[$urandom_range(op_texts.size() - 1)]);
      7: begin
        n = $urandom_range(1) ? 8'h22 : 8'h27;
        src_text.push_back(8'(n));
        repeat ($urandom_range(0, 4)) src_text.push_back(8'($urandom_range(32, 126)));
        // sometimes leave the string open
        if ($urandom_range(5) != 0) src_text.push_back(8'(n));
      end
      8: begin
        add_text("//");
        repeat ($urandom_range(0, 4)) src_text.push_back(8'($urandom_range(255)));
        src_text.push_back(8'h0A);
      end
      9: src_text.push_back($urandom_range(1) ? 8'h09 : 8'h0D);
      default: src_text.push_back(8'($urandom_range(255)));
    endcase
    if ($urandom_range(2) == 0) src_text.push_back(" ");
  endtask

  task automatic random_phase(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      repeat ($urandom_range(3, 25)) add_lexeme();
      send_source();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keyword, identifier, two-char op, string, bad byte,
    // integer then dot, decimal, and max byte values
    add_text("ab_9 return!=");
    src_text.push_back(8'h22); add_text("s"); src_text.push_back(8'h22);
    add_text("@12.x 3.5 ");
    src_text.push_back(8'hFF);
    send_source();
    // Integer saturation, then an open string at end
    add_text("2147483648 '");
    add_text("op");
    send_source();

    // Phase one: sender idles rarely, receiver often; one long receiver hold
    hold_requests++;
    random_phase(110);
    send_idle_pct = 48;
    recv_idle_pct = 22;
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(100);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d sources, %0d source bytes of directed and random text,",
             sources_sent, bytes_sent);
    $display("with random idling on both sides and a long receiver hold.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### script_lexer_stream.f
rtl/sls_pkg.sv
rtl/sls_front.sv
rtl/sls_queue.sv
rtl/script_lexer_stream.sv
tb/script_lexer_stream_checker.sv
tb/tb_script_lexer_stream.sv
